@@ hdl/aging_priority_scheduler_top_defines.svh @@
// Assertion macros shared by the scheduler RTL.
`ifndef AGING_PRIORITY_SCHEDULER_TOP_DEFINES_SVH
`define AGING_PRIORITY_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication.
`define APS_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define APS_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/aps_pkg.sv @@
package aps_pkg;

   localparam int N_SLOTS_DEF = 16;

   localparam int OP_W     = 3;
   localparam int SLOT_FW  = 4;
   localparam int PIN_W    = 7;
   localparam int STATUS_W = 2;
   localparam int PRIO_W   = 6;

   typedef logic signed [PRIO_W-1:0] prio_type;
   typedef logic signed [PIN_W-1:0]  prio_in_type;

   localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
   localparam logic [OP_W-1:0] OP_SET    = 3'd2;
   localparam logic [OP_W-1:0] OP_GET    = 3'd3;
   localparam logic [OP_W-1:0] OP_SCHED  = 3'd4;

   localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STS_NONE  = 2'd1;
   localparam logic [STATUS_W-1:0] STS_WRONG = 2'd2;

   localparam prio_type PRIO_MAX = 6'sd20;
   localparam prio_type PRIO_MIN = -6'sd20;

   function automatic prio_type clamp_prio(input prio_in_type p);
      prio_type r;
      if (p > PIN_W'(PRIO_MAX)) begin
         r = PRIO_MAX;
      end else if (p < PIN_W'(PRIO_MIN)) begin
         r = PRIO_MIN;
      end else begin
         r = prio_type'(p);
      end
      return r;
   endfunction

endpackage

@@ hdl/aging_priority_scheduler_top.sv @@
// Channel  Direction  Handshake          Payload
// req      in         req_valid/ready    req_op, req_slot, req_priority_in, req_use_current
// rsp      out        rsp_valid/ready    rsp_status, rsp_selected_slot, rsp_priority_out
//
// One item is in flight at a time; req_ready is high only while the sequencer is idle.
// Add, set, get and every rejected item go from look-up to done; an accepted remove first
// scans all slots in ST_REM and a schedule with a ready task in ST_SCHED, then ST_RELOAD.
// Synchronous active-high reset clears the whole slot table, the state, counters and valid flags.
// A finished result waits in the output register; the next item is accepted meanwhile,
// and a stalled rsp channel only holds the following result in its final step.
`include "aging_priority_scheduler_top_defines.svh"

module aging_priority_scheduler_top
   import aps_pkg::*;
#(
   parameter int N_SLOTS = N_SLOTS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [OP_W-1:0]            req_op,
   input  logic [SLOT_FW-1:0]         req_slot,
   input  logic signed [PIN_W-1:0]    req_priority_in,
   input  logic                       req_use_current,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [SLOT_FW-1:0]         rsp_selected_slot,
   output logic signed [PRIO_W-1:0]   rsp_priority_out
);

   localparam int SLOT_W = $clog2(N_SLOTS);
   localparam int RANK_W = SLOT_W;
   localparam int CNT_W  = $clog2(N_SLOTS + 1);
   localparam int CMP_W  = 7;
   localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(N_SLOTS - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOOK   = 3'd1;
   localparam logic [2:0] ST_REM    = 3'd2;
   localparam logic [2:0] ST_SCHED  = 3'd3;
   localparam logic [2:0] ST_RELOAD = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   typedef struct packed {
      logic              rdy;
      prio_type          stat;
      prio_type          dyn;
      logic [RANK_W-1:0] rank;
   } entry_type;

   logic [2:0]            state_ff, state_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [SLOT_FW-1:0]    slot_ff, slot_in;
   prio_type              prio_ff, prio_in;
   logic                  usecur_ff, usecur_in;
   logic [SLOT_W-1:0]     cnt_ff, cnt_in;
   logic [RANK_W-1:0]     rank_s_ff, rank_s_in;
   logic [SLOT_W-1:0]     best_ff, best_in;
   logic                  best_v_ff, best_v_in;
   prio_type              best_dyn_ff, best_dyn_in;
   logic [RANK_W-1:0]     best_rank_ff, best_rank_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [SLOT_FW-1:0]    res_sel_ff, res_sel_in;
   prio_type              res_prio_ff, res_prio_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [SLOT_W-1:0]     cur_slot_ff, cur_slot_in;
   logic                  cur_v_ff, cur_v_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [SLOT_FW-1:0]    rsp_sel_ff, rsp_sel_in;
   prio_type              rsp_prio_ff, rsp_prio_in;

   logic [N_SLOTS-1:0]    rdy_ff;
   prio_type              stat_ff [N_SLOTS];
   prio_type              dyn_ff [N_SLOTS];
   logic [RANK_W-1:0]     rank_ff [N_SLOTS];

   logic [SLOT_W-1:0]     slot_idx;
   logic [SLOT_W-1:0]     addr;
   logic                  in_range;
   entry_type             rd_ent;
   entry_type             wr_ent;
   logic                  wr_en;
   prio_type              aged;
   logic                  better;

   assign slot_idx = SLOT_W'(slot_ff);
   assign in_range = CMP_W'(slot_ff) < CMP_W'(N_SLOTS);

   always_comb begin
      unique case (state_ff)
         ST_LOOK: begin
            addr = (op_ff == OP_GET && usecur_ff) ? cur_slot_ff : slot_idx;
         end
         ST_RELOAD: begin
            addr = best_ff;
         end
         default: begin
            addr = cnt_ff;
         end
      endcase
   end

   assign rd_ent.rdy  = rdy_ff[addr];
   assign rd_ent.stat = stat_ff[addr];
   assign rd_ent.dyn  = dyn_ff[addr];
   assign rd_ent.rank = rank_ff[addr];

   assign aged   = (rd_ent.dyn > PRIO_MIN) ? prio_type'(rd_ent.dyn - 6'sd1) : rd_ent.dyn;
   assign better = !best_v_ff || (aged < best_dyn_ff) ||
                   ((aged == best_dyn_ff) && (rd_ent.rank < best_rank_ff));

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      prio_in       = prio_ff;
      usecur_in     = usecur_ff;
      cnt_in        = cnt_ff;
      rank_s_in     = rank_s_ff;
      best_in       = best_ff;
      best_v_in     = best_v_ff;
      best_dyn_in   = best_dyn_ff;
      best_rank_in  = best_rank_ff;
      res_status_in = res_status_ff;
      res_sel_in    = res_sel_ff;
      res_prio_in   = res_prio_ff;
      count_in      = count_ff;
      cur_slot_in   = cur_slot_ff;
      cur_v_in      = cur_v_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_sel_in    = rsp_sel_ff;
      rsp_prio_in   = rsp_prio_ff;
      wr_en         = 1'b0;
      wr_ent        = rd_ent;
      req_ready     = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in     = req_op;
               slot_in   = req_slot;
               prio_in   = clamp_prio(req_priority_in);
               usecur_in = req_use_current;
               cnt_in    = '0;
               best_v_in = 1'b0;
               state_in  = ST_LOOK;
            end
         end
         ST_LOOK: begin
            res_status_in = STS_OK;
            res_sel_in    = '0;
            res_prio_in   = '0;
            state_in      = ST_DONE;
            unique case (op_ff)
               OP_ADD: begin
                  if (!in_range || rd_ent.rdy) begin
                     res_status_in = STS_WRONG;
                  end else begin
                     wr_en       = 1'b1;
                     wr_ent.rdy  = 1'b1;
                     wr_ent.stat = '0;
                     wr_ent.dyn  = '0;
                     wr_ent.rank = RANK_W'(count_ff);
                     count_in    = count_ff + CNT_W'(1);
                  end
               end
               OP_REMOVE: begin
                  if (!in_range || !rd_ent.rdy) begin
                     res_status_in = STS_WRONG;
                  end else begin
                     rank_s_in = rd_ent.rank;
                     state_in  = ST_REM;
                  end
               end
               OP_SET: begin
                  if (!in_range) begin
                     res_status_in = STS_WRONG;
                  end else begin
                     wr_en       = 1'b1;
                     wr_ent.stat = prio_ff;
                     wr_ent.dyn  = prio_ff;
                  end
               end
               OP_GET: begin
                  if (usecur_ff) begin
                     if (!cur_v_ff) begin
                        res_status_in = STS_NONE;
                     end else begin
                        res_prio_in = rd_ent.stat;
                     end
                  end else if (!in_range) begin
                     res_status_in = STS_WRONG;
                  end else begin
                     res_prio_in = rd_ent.stat;
                  end
               end
               OP_SCHED: begin
                  if (count_ff == '0) begin
                     res_status_in = STS_NONE;
                  end else begin
                     state_in = ST_SCHED;
                  end
               end
               default: begin
                  res_status_in = STS_WRONG;
               end
            endcase
         end
         ST_REM: begin
            if (rd_ent.rdy && (rd_ent.rank > rank_s_ff)) begin
               wr_en       = 1'b1;
               wr_ent.rank = rd_ent.rank - RANK_W'(1);
            end
            if (cnt_ff == slot_idx) begin
               wr_en       = 1'b1;
               wr_ent.rdy  = 1'b0;
               wr_ent.rank = '0;
               count_in    = count_ff - CNT_W'(1);
               if (cur_v_ff && (cur_slot_ff == slot_idx)) begin
                  cur_v_in = 1'b0;
               end
            end
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + SLOT_W'(1);
            end
         end
         ST_SCHED: begin
            if (rd_ent.rdy) begin
               wr_en      = 1'b1;
               wr_ent.dyn = aged;
               if (better) begin
                  best_in      = cnt_ff;
                  best_v_in    = 1'b1;
                  best_dyn_in  = aged;
                  best_rank_in = rd_ent.rank;
               end
            end
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_RELOAD;
            end else begin
               cnt_in = cnt_ff + SLOT_W'(1);
            end
         end
         ST_RELOAD: begin
            if (best_v_ff) begin
               wr_en       = 1'b1;
               wr_ent.dyn  = rd_ent.stat;
               cur_slot_in = best_ff;
               cur_v_in    = 1'b1;
               res_sel_in  = SLOT_FW'(best_ff);
            end else begin
               res_status_in = STS_NONE;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_sel_in    = res_sel_ff;
               rsp_prio_in   = res_prio_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cur_slot_ff  <= '0;
         cur_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         best_v_ff    <= 1'b0;
         cnt_ff       <= '0;
         rdy_ff       <= '0;
         for (int i = 0; i < N_SLOTS; i++) begin
            stat_ff[i] <= '0;
            dyn_ff[i]  <= '0;
            rank_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cur_slot_ff  <= cur_slot_in;
         cur_v_ff     <= cur_v_in;
         rsp_valid_ff <= rsp_valid_in;
         best_v_ff    <= best_v_in;
         cnt_ff       <= cnt_in;
         if (wr_en) begin
            rdy_ff[addr]  <= wr_ent.rdy;
            stat_ff[addr] <= wr_ent.stat;
            dyn_ff[addr]  <= wr_ent.dyn;
            rank_ff[addr] <= wr_ent.rank;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      slot_ff       <= slot_in;
      prio_ff       <= prio_in;
      usecur_ff     <= usecur_in;
      rank_s_ff     <= rank_s_in;
      best_ff       <= best_in;
      best_dyn_ff   <= best_dyn_in;
      best_rank_ff  <= best_rank_in;
      res_status_ff <= res_status_in;
      res_sel_ff    <= res_sel_in;
      res_prio_ff   <= res_prio_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sel_ff    <= rsp_sel_in;
      rsp_prio_ff   <= rsp_prio_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_selected_slot = rsp_sel_ff;
   assign rsp_priority_out  = rsp_prio_ff;

   `APS_ASSERT_NOW(a_count_matches_flags, clock, reset, 1'b1,
      $countones(rdy_ff) == int'(count_ff), "ready count disagrees with ready flags")
   `APS_ASSERT_NOW(a_current_is_ready, clock, reset, cur_v_ff,
      rdy_ff[cur_slot_ff], "current task is not ready")
   `APS_ASSERT_NEXT(a_one_item_at_a_time, clock, reset, req_valid && req_ready,
      !req_ready, "new transfer accepted while busy")

endmodule
